>>> rtl/lsfc_pkg.sv
// Package for the LED strip frame controller.
// Holds field widths, register map, reset values, state codes and the byte ordering function.
// No dependencies.
`default_nettype none

package lsfc_pkg;

  localparam int unsigned IDX_W     = 4;
  localparam int unsigned MASK_W    = 16;
  localparam int unsigned PIXEL_W   = 24;
  localparam int unsigned S_DATA_W  = 48;
  localparam int unsigned M_DATA_W  = 32;
  localparam int unsigned ADDR_W    = 5;
  localparam int unsigned REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_COLOUR_ORDER = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_FLASH_COUNT  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_WAIT_TICKS   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BOOT_RED     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BOOT_GREEN   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_BOOT_BLUE    = 3'd5;

  localparam logic [1:0]  RST_COLOUR_ORDER = 2'd2;
  localparam logic [7:0]  RST_FLASH_COUNT  = 8'd3;
  localparam logic [15:0] RST_WAIT_TICKS   = 16'd150;
  localparam logic [7:0]  RST_BOOT_RED     = 8'd0;
  localparam logic [7:0]  RST_BOOT_GREEN   = 8'd0;
  localparam logic [7:0]  RST_BOOT_BLUE    = 8'd128;

  localparam logic [1:0] ORDER_GBR = 2'd0;
  localparam logic [1:0] ORDER_RGB = 2'd1;

  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_MSG  = 1'b1;

  localparam logic KIND_PIXEL  = 1'b0;
  localparam logic KIND_REJECT = 1'b1;

  typedef enum logic [3:0] {
    BM_ON   = 4'b0001,
    BM_OFF  = 4'b0010,
    BM_WAIT = 4'b0100,
    BM_IDLE = 4'b1000
  } boot_mode_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_WRITE  = 4'b0010,
    ST_EMIT   = 4'b0100,
    ST_REJECT = 4'b1000
  } seq_state_t;

  // Returns the wire bytes of a pixel with the first byte in the low bits.
  function automatic logic [PIXEL_W-1:0] order_bytes(input logic [1:0] order,
                                                    input logic [7:0] r,
                                                    input logic [7:0] g,
                                                    input logic [7:0] b);
    logic [PIXEL_W-1:0] res;
    if (order == ORDER_GBR) begin
      res = {r, b, g};
    end else if (order == ORDER_RGB) begin
      res = {b, g, r};
    end else begin
      res = {b, r, g};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> rtl/lsfc_pixel_store.sv
// Pixel store of the LED strip frame controller: one write port, one registered read port.
// A read of the address written at the same edge returns the new data. Depends on lsfc_pkg.
`default_nettype none

module lsfc_pixel_store import lsfc_pkg::*; #(
  parameter int unsigned NUM_PIXELS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               we,
  input  wire logic [IDX_W-1:0]   waddr,
  input  wire logic [PIXEL_W-1:0] wdata,
  input  wire logic [IDX_W-1:0]   raddr,
  output logic      [PIXEL_W-1:0] rdata
);

  localparam int unsigned AW = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;

  logic [PIXEL_W-1:0] pix [NUM_PIXELS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PIXELS; i++) begin
        pix[i] <= '0;
      end
    end else if (we) begin
      pix[waddr[AW-1:0]] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= pix[raddr[AW-1:0]];
    end
  end

endmodule

`default_nettype wire

>>> rtl/led_strip_frame_controller_top.sv
// LED strip frame controller: boot flash sequencer, pixel writer and frame emitter.
// An input transaction that emits a frame keeps the input busy through the accept, the write
// walk over every pixel and the emit of one pixel per cycle while the output accepts it. A
// message with more pending takes the accept and write walk, a rejected message the accept
// and reject beat, a tick without a frame the accept only; output stalls lengthen these.
// Synchronous reset loads the register reset values, restarts the boot sequence at flash on
// and clears the pixel store. Depends on lsfc_pkg and lsfc_pixel_store.
`default_nettype none

module led_strip_frame_controller_top import lsfc_pkg::*; #(
  parameter int unsigned NUM_PIXELS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ADDR_W-1:0]   paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // led_mask[15:0], red[23:16], green[31:24], blue[39:32], more_pending[40], zero[47:41]
  input  wire logic [S_DATA_W-1:0] s_axis_tdata,
  // action[0]
  input  wire logic                s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // pixel_index[3:0], first_byte[11:4], second_byte[19:12], third_byte[27:20], zero[31:28]
  output logic      [M_DATA_W-1:0] m_axis_tdata,
  // kind[0]
  output logic                     m_axis_tuser,
  output logic                     m_axis_tlast
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PIXELS - 1);

  logic [1:0]  colour_order;
  logic [7:0]  flash_count;
  logic [15:0] wait_ticks;
  logic [7:0]  boot_red;
  logic [7:0]  boot_green;
  logic [7:0]  boot_blue;

  boot_mode_t mode;
  boot_mode_t next_mode;
  logic [7:0]  flashes_left;
  logic [15:0] elapsed;

  seq_state_t         state;
  logic [IDX_W-1:0]   idx;
  logic [MASK_W-1:0]  wr_mask;
  logic [PIXEL_W-1:0] wr_colour;
  logic               emit_after;

  logic [IDX_W-1:0]   out_index;
  logic [PIXEL_W-1:0] out_bytes;
  logic               out_kind;
  logic               out_last;

  logic [PIXEL_W-1:0] rd_pixel;
  logic [IDX_W-1:0]   rd_addr;
  logic               store_we;
  logic               out_free;
  logic               cfg_we;
  logic [REG_IDX_W-1:0] cfg_idx;
  logic [7:0]         flashes_dec;

  logic [MASK_W-1:0]  in_mask;
  logic [7:0]         in_red;
  logic [7:0]         in_green;
  logic [7:0]         in_blue;
  logic               in_more;

  assign in_mask  = s_axis_tdata[15:0];
  assign in_red   = s_axis_tdata[23:16];
  assign in_green = s_axis_tdata[31:24];
  assign in_blue  = s_axis_tdata[39:32];
  assign in_more  = s_axis_tdata[40];

  assign pready  = 1'b1;
  assign cfg_idx = paddr[ADDR_W-1:2];
  assign cfg_we  = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_COLOUR_ORDER: prdata = {30'd0, colour_order};
      REG_FLASH_COUNT:  prdata = {24'd0, flash_count};
      REG_WAIT_TICKS:   prdata = {16'd0, wait_ticks};
      REG_BOOT_RED:     prdata = {24'd0, boot_red};
      REG_BOOT_GREEN:   prdata = {24'd0, boot_green};
      REG_BOOT_BLUE:    prdata = {24'd0, boot_blue};
      default:          prdata = '0;
    endcase
  end

  // The read address runs one pixel ahead of the emitter so that the registered
  // store output holds the pixel at idx whenever the emitter is in ST_EMIT.
  always_comb begin
    rd_addr = '0;
    if (state == ST_EMIT) begin
      if (out_free && (idx != LAST_IDX)) begin
        rd_addr = idx + 1'b1;
      end else begin
        rd_addr = idx;
      end
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign store_we      = (state == ST_WRITE) && wr_mask[idx];
  assign flashes_dec   = (flashes_left != 8'd0) ? flashes_left - 8'd1 : 8'd0;

  assign m_axis_tdata = {4'd0, out_bytes, out_index};
  assign m_axis_tuser = out_kind;
  assign m_axis_tlast = out_last;

  lsfc_pixel_store #(
    .NUM_PIXELS(NUM_PIXELS)
  ) u_store (
    .clk  (clk),
    .rst  (rst),
    .we   (store_we),
    .waddr(idx),
    .wdata(wr_colour),
    .raddr(rd_addr),
    .rdata(rd_pixel)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      colour_order  <= RST_COLOUR_ORDER;
      flash_count   <= RST_FLASH_COUNT;
      wait_ticks    <= RST_WAIT_TICKS;
      boot_red      <= RST_BOOT_RED;
      boot_green    <= RST_BOOT_GREEN;
      boot_blue     <= RST_BOOT_BLUE;
      mode          <= BM_ON;
      next_mode     <= BM_OFF;
      flashes_left  <= RST_FLASH_COUNT;
      elapsed       <= '0;
      state         <= ST_IDLE;
      idx           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            idx <= '0;
            if (s_axis_tuser == ACT_MSG) begin
              if (mode != BM_IDLE) begin
                state <= ST_REJECT;
              end else begin
                wr_mask    <= in_mask;
                wr_colour  <= order_bytes(colour_order, in_red, in_green, in_blue);
                emit_after <= !in_more;
                state      <= ST_WRITE;
              end
            end else begin
              unique case (mode)
                BM_ON: begin
                  wr_mask    <= '1;
                  wr_colour  <= order_bytes(colour_order, boot_red, boot_green, boot_blue);
                  emit_after <= 1'b1;
                  state      <= ST_WRITE;
                  next_mode  <= BM_OFF;
                  mode       <= BM_WAIT;
                  elapsed    <= '0;
                end
                BM_OFF: begin
                  wr_mask      <= '1;
                  wr_colour    <= '0;
                  emit_after   <= 1'b1;
                  state        <= ST_WRITE;
                  flashes_left <= flashes_dec;
                  next_mode    <= (flashes_dec == 8'd0) ? BM_IDLE : BM_ON;
                  mode         <= BM_WAIT;
                  elapsed      <= '0;
                end
                BM_WAIT: begin
                  if (elapsed >= wait_ticks) begin
                    mode <= next_mode;
                  end else begin
                    elapsed <= elapsed + 16'd1;
                  end
                end
                BM_IDLE: begin
                end
              endcase
            end
          end
        end
        ST_WRITE: begin
          if (idx == LAST_IDX) begin
            idx   <= '0;
            state <= emit_after ? ST_EMIT : ST_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            out_kind      <= KIND_PIXEL;
            out_index     <= idx;
            out_bytes     <= rd_pixel;
            out_last      <= (idx == LAST_IDX);
            if (idx == LAST_IDX) begin
              idx   <= '0;
              state <= ST_IDLE;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        ST_REJECT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            out_kind      <= KIND_REJECT;
            out_index     <= '0;
            out_bytes     <= '0;
            out_last      <= 1'b1;
            state         <= ST_IDLE;
          end
        end
      endcase

      if (cfg_we) begin
        unique case (cfg_idx)
          REG_COLOUR_ORDER: colour_order <= pwdata[1:0];
          REG_FLASH_COUNT: begin
            flash_count <= pwdata[7:0];
            if (mode != BM_IDLE) begin
              flashes_left <= pwdata[7:0];
            end
          end
          REG_WAIT_TICKS:   wait_ticks <= pwdata[15:0];
          REG_BOOT_RED:     boot_red   <= pwdata[7:0];
          REG_BOOT_GREEN:   boot_green <= pwdata[7:0];
          REG_BOOT_BLUE:    boot_blue  <= pwdata[7:0];
          default: begin
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire
